// File: src/ialu_pkg.sv
// ----------------------------------------------------------------------------
// ialu_pkg: shared types and codes of the gcd/lcm integer ALU
// Operation codes, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package ialu_pkg;

    localparam int unsigned ACT_W  = 3;
    localparam int unsigned STAT_W = 2;

    typedef enum logic [ACT_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4,
        OP_SGN = 3'd5,
        OP_GCD = 3'd6,
        OP_LCM = 3'd7
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,     // serial divide, one quotient bit a cycle
        S_MUL,     // serial multiply, one multiplier bit a cycle
        S_GCD,     // run the divider for one Euclid step
        S_LCMD,    // divide |a| by gcd
        S_LCMM,    // multiply quotient by |b|
        S_POWM,    // power: one squaring-free multiply r*=base
        S_DONE
    } t_state;

endpackage

// File: src/integer_alu_gcd_lcm.sv
// ----------------------------------------------------------------------------
// integer_alu_gcd_lcm: signed integer ALU with gcd and lcm
// Add/sub without the serial units; multiply, divide, power, gcd and lcm through a
// serial shift-add multiplier and a restoring divider.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | i_valid/o_ready, i_action, i_operand_a/_b | into block
//  out     | o_valid/i_ready, o_value, o_status        | out of block
//
//  Add, sub and signs-equal finish without the serial units. Mul and div
//  use one serial run each; gcd one divide per Euclid step; power one
//  multiply per exponent step, up to W-1 multiplies; lcm a gcd, a divide
//  and a multiply. One item at a time.
//  Reset clears the sequencer and output valid. A stalled result holds.
// ----------------------------------------------------------------------------
module integer_alu_gcd_lcm import ialu_pkg::*; #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ACT_W-1:0]      i_action,
    input  logic [DATA_WIDTH-1:0] i_operand_a,
    input  logic [DATA_WIDTH-1:0] i_operand_b,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_WIDTH-1:0] o_value,
    output logic [STAT_W-1:0]     o_status
);
    localparam int unsigned W = DATA_WIDTH;
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ONE  = W'(1);

    t_state r_state, n_state;
    t_op    r_op;
    logic [W-1:0] r_a, r_b;         // magnitudes (MIN reads as 2^(W-1))
    logic         r_na, r_nb;
    logic [W-1:0] r_x, r_y;         // gcd pair, power result / exponent
    logic [W-1:0] r_value, n_value;
    logic [STAT_W-1:0] r_status, n_status;
    logic         r_valid, n_valid;

    logic         w_accept;
    logic [W-1:0] w_ma, w_mb;
    logic         d_start, m_start;
    logic [W-1:0] d_num, d_den, m_mc, m_mp;
    logic         d_busy, m_busy;
    logic [W-1:0] d_quo, d_rem;
    logic [2*W-1:0] m_prod;
    logic         r_started;
    logic         n_started;
    logic [W-1:0] n_x, n_y;
    logic         w_neg;
    logic [W:0]   w_lim;
    logic         w_big;
    logic [W-1:0] w_sum, w_dif;

    assign o_ready  = (r_state == S_IDLE) && (!r_valid || i_ready);
    assign w_accept = i_valid && o_ready;
    assign w_ma = i_operand_a[W-1] ? (~i_operand_a + 1'b1) : i_operand_a;
    assign w_mb = i_operand_b[W-1] ? (~i_operand_b + 1'b1) : i_operand_b;

    ialu_div #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start),
        .i_num(d_num), .i_den(d_den), .o_busy(d_busy),
        .o_quo(d_quo), .o_rem(d_rem)
    );

    ialu_mul #(.W(W)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(m_start),
        .i_mcand(m_mc), .i_mplier(m_mp), .o_busy(m_busy), .o_prod(m_prod)
    );

    // Signed-result helpers
    assign w_neg = (r_op == OP_POW) ? (r_na && r_b[0]) : (r_na != r_nb);
    assign w_lim = w_neg ? {1'b0, SMIN} : {1'b0, SMAX};
    assign w_big = (m_prod[2*W-1:W] != '0) || ({1'b0, m_prod[W-1:0]} > w_lim);
    assign w_sum = i_operand_a + i_operand_b;
    assign w_dif = i_operand_a - i_operand_b;

    // Hold the sequencer state, output valid and the unit-started flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_started <= n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= t_op'(i_action);
            r_a  <= w_ma;
            r_b  <= w_mb;
            r_na <= i_operand_a[W-1];
            r_nb <= i_operand_b[W-1];
        end
        r_x      <= n_x;
        r_y      <= n_y;
        r_value  <= n_value;
        r_status <= n_status;
    end

    // Next state and unit control
    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_value   = r_value;
        n_status  = r_status;
        n_x       = r_x;
        n_y       = r_y;
        n_started = r_started;
        d_start   = 1'b0;
        m_start   = 1'b0;
        d_num     = r_x;
        d_den     = r_y;
        m_mc      = r_x;
        m_mp      = r_a;
        if (r_valid && i_ready) n_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    n_x = w_ma;
                    n_y = w_mb;
                    case (t_op'(i_action))
                        OP_ADD: begin
                            n_value = w_sum;
                            if (i_operand_a[W-1] == i_operand_b[W-1]
                                && w_sum[W-1] != i_operand_a[W-1]) n_status = ST_OVF;
                            n_state = S_DONE;
                        end
                        OP_SUB: begin
                            n_value = w_dif;
                            if (i_operand_a[W-1] != i_operand_b[W-1]
                                && w_dif[W-1] != i_operand_a[W-1]) n_status = ST_OVF;
                            n_state = S_DONE;
                        end
                        OP_SGN: begin
                            n_value = (w_ma != '0 && w_mb != '0
                                && i_operand_a[W-1] == i_operand_b[W-1]) ? ONE : '0;
                            n_state = S_DONE;
                        end
                        OP_MUL: begin
                            m_start = 1'b1;
                            m_mc = w_ma;
                            m_mp = w_mb;
                            n_state = S_MUL;
                        end
                        OP_DIV: begin
                            if (w_mb == '0) begin
                                n_value = '0;
                                n_status = ST_DIVZ;
                                n_state = S_DONE;
                            end else begin
                                d_start = 1'b1;
                                d_num = w_ma;
                                d_den = w_mb;
                                n_state = S_DIV;
                            end
                        end
                        OP_POW: begin
                            n_x = ONE;      // running result
                            n_y = w_mb;     // remaining exponent
                            n_state = S_POWM;
                        end
                        default: begin      // gcd and lcm
                            n_started = 1'b0;
                            n_state = S_GCD;
                        end
                    endcase
                end
            end
            S_MUL: begin
                if (!m_busy) begin
                    n_value = (r_na != r_nb) ? (~m_prod[W-1:0] + 1'b1) : m_prod[W-1:0];
                    n_status = w_big ? ST_OVF : ST_OK;
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (!d_busy) begin
                    n_value = (r_na != r_nb) ? (~d_quo + 1'b1) : d_quo;
                    n_status = (r_na == r_nb && d_quo[W-1]) ? ST_OVF : ST_OK;
                    n_state = S_DONE;
                end
            end
            S_POWM: begin
                if (r_nb) begin
                    // Negative exponent
                    if (r_a == ONE) n_value = (r_na && r_b[0]) ? '1 : ONE;
                    else if (r_a == '0) begin
                        n_value = '0;
                        n_status = ST_DIVZ;
                    end else n_value = '0;
                    n_state = S_DONE;
                end else if (!r_started) begin
                    if (r_y == '0) begin
                        n_value = w_neg ? (~r_x + 1'b1) : r_x;
                        n_state = S_DONE;
                    end else if (r_a <= ONE) begin
                        n_value = w_neg ? (~r_a + 1'b1) : r_a;
                        n_state = S_DONE;
                    end else if (r_b >= W'(W)) begin
                        n_value = w_neg ? SMIN : SMAX;
                        n_status = ST_OVF;
                        n_state = S_DONE;
                    end else begin
                        m_start = 1'b1;
                        m_mc = r_x;
                        m_mp = r_a;
                        n_started = 1'b1;
                    end
                end else if (!m_busy) begin
                    n_started = 1'b0;
                    if (w_big) begin
                        n_value = w_neg ? SMIN : SMAX;
                        n_status = ST_OVF;
                        n_state = S_DONE;
                    end else begin
                        n_x = m_prod[W-1:0];
                        n_y = r_y - 1'b1;
                    end
                end
            end
            S_GCD: begin
                if (!r_started) begin
                    if (r_y == '0) begin
                        if (r_op == OP_GCD) begin
                            n_value = r_x[W-1] ? SMAX : r_x;
                            n_status = r_x[W-1] ? ST_OVF : ST_OK;
                            n_state = S_DONE;
                        end else if (r_a == '0 || r_b == '0) begin
                            n_value = '0;
                            n_state = S_DONE;
                        end else begin
                            d_start = 1'b1;
                            d_num = r_a;
                            d_den = r_x;
                            n_started = 1'b1;
                            n_state = S_LCMD;
                        end
                    end else begin
                        d_start = 1'b1;
                        n_started = 1'b1;
                    end
                end else if (!d_busy) begin
                    n_started = 1'b0;
                    n_x = r_y;
                    n_y = d_rem;
                end
            end
            S_LCMD: begin
                if (!d_busy) begin
                    n_started = 1'b0;
                    m_start = 1'b1;
                    m_mc = d_quo;
                    m_mp = r_b;
                    n_state = S_LCMM;
                end
            end
            S_LCMM: begin
                if (!m_busy) begin
                    if (m_prod[2*W-1:W] != '0 || m_prod[W-1]) begin
                        n_value = SMAX;
                        n_status = ST_OVF;
                    end else n_value = m_prod[W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

    // Status never reports an undefined code
    property p_stat;
        @(posedge i_clk) disable iff (!i_rst_n) r_valid |-> r_status != 2'd3;
    endproperty
    a_stat: assert property (p_stat) else $error("bad status code");

    property p_one;
        @(posedge i_clk) disable iff (!i_rst_n) w_accept |=> r_state != S_IDLE;
    endproperty
    a_one: assert property (p_one) else $error("item dropped");

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_valid && !i_ready |=> r_valid && $stable(r_value);
    endproperty
    a_hold: assert property (p_hold) else $error("result lost under stall");

    property p_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_state == S_IDLE |-> !d_busy && !m_busy;
    endproperty
    a_busy: assert property (p_busy) else $error("unit busy while idle");
endmodule

// File: src/ialu_div.sv
// ----------------------------------------------------------------------------
// ialu_div: restoring divider on magnitudes
// One quotient bit per cycle through a shift register.
// ----------------------------------------------------------------------------
module ialu_div import ialu_pkg::*; #(
    parameter int unsigned W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_busy,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_quo, n_quo;
    logic [W:0]    r_rem, n_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    w_try;
    logic [W:0]    w_sub;

    // Shift in the next numerator bit and trial-subtract
    always_comb begin
        w_try = {r_rem[W-1:0], r_quo[W-1]};
        w_sub = w_try - {1'b0, r_den};
        if (!w_sub[W]) begin
            n_rem = w_sub;
            n_quo = {r_quo[W-2:0], 1'b1};
        end else begin
            n_rem = w_try;
            n_quo = {r_quo[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[W-1:0];

    // Remainder stays below the divisor after every step
    property p_rem_small;
        @(posedge i_clk) disable iff (!i_rst_n)
            $past(r_busy) && r_den != '0 |-> r_rem < {1'b0, r_den};
    endproperty
    a_rem_small: assert property (p_rem_small) else $error("remainder too large");

    property p_len;
        @(posedge i_clk) disable iff (!i_rst_n) i_start |=> r_busy;
    endproperty
    a_len: assert property (p_len) else $error("divider did not start");

    property p_cnt;
        @(posedge i_clk) disable iff (!i_rst_n) !r_busy |-> r_cnt == '0 || !$past(r_busy);
    endproperty
    a_cnt: assert property (p_cnt) else $error("divider count left over");
endmodule

// File: src/ialu_mul.sv
// ----------------------------------------------------------------------------
// ialu_mul: shift-add multiplier on magnitudes
// One multiplier bit per cycle; 2W-bit exact product once busy drops.
// ----------------------------------------------------------------------------
module ialu_mul import ialu_pkg::*; #(
    parameter int unsigned W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_mcand,
    input  logic [W-1:0]   i_mplier,
    output logic           o_busy,
    output logic [2*W-1:0] o_prod
);
    localparam int unsigned CW = $clog2(W + 1);

    logic [2*W-1:0] r_acc;
    logic [W-1:0]   r_mc;
    logic [W-1:0]   r_mp;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic [W:0]     w_sum;

    // Add the multiplicand into the upper half when the low bit is set
    assign w_sum = {1'b0, r_acc[2*W-1:W]} + (r_mp[0] ? {1'b0, r_mc} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_mc  <= i_mcand;
            r_mp  <= i_mplier;
        end else if (r_busy) begin
            r_acc <= {w_sum, r_acc[W-1:1]};
            r_mp  <= {1'b0, r_mp[W-1:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_acc;

    property p_run;
        @(posedge i_clk) disable iff (!i_rst_n) i_start |=> r_busy;
    endproperty
    a_run: assert property (p_run) else $error("multiplier did not start");

    property p_end;
        @(posedge i_clk) disable iff (!i_rst_n) $fell(r_busy) |-> r_mp == '0;
    endproperty
    a_end: assert property (p_end) else $error("multiplier bits left over");

    property p_zero;
        @(posedge i_clk) disable iff (!i_rst_n) $rose(r_busy) |-> r_acc == '0;
    endproperty
    a_zero: assert property (p_zero) else $error("accumulator not cleared");
endmodule

// File: verif/tb_integer_alu_gcd_lcm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_alu_gcd_lcm: self-checking bench for the gcd/lcm integer ALU
// Drives directed corner items and random items for every operation through
// the valid/ready input channel, predicts value and status with a behavioral
// model at full width, and compares each result item in order.
// ----------------------------------------------------------------------------
module tb_integer_alu_gcd_lcm;
    import ialu_pkg::*;

    localparam int unsigned W = 32;
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    logic [2:0]    i_action;
    logic [W-1:0]  i_operand_a;
    logic [W-1:0]  i_operand_b;
    logic          o_valid;
    logic          i_ready;
    logic [W-1:0]  o_value;
    logic [1:0]    o_status;

    typedef struct packed {
        logic [W-1:0] value;
        t_status      status;
    } t_alu_result;

    t_alu_result alu_results_due[$];
    int          error_count;
    int          items_sent;
    int          results_seen;
    bit          hold_off_req;
    bit          rx_idle_en;

    integer_alu_gcd_lcm #(.DATA_WIDTH(W)) dut (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Limit the run time
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [W:0] mag_of(logic [W-1:0] x);
        return x[W-1] ? ({1'b0, ~x} + 1'b1) : {1'b0, x};
    endfunction

    function automatic logic [W:0] euclid(logic [W:0] x, logic [W:0] y);
        logic [W:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Compute the expected value and status of one item
    function automatic t_alu_result alu_predict(t_op op, logic [W-1:0] a, logic [W-1:0] b);
        t_alu_result res;
        logic        na, nb, neg;
        logic [W:0]  ma, mb, q, g, lim;
        logic [2*W+1:0] p, r;
        int i;
        na = a[W-1];
        nb = b[W-1];
        ma = mag_of(a);
        mb = mag_of(b);
        res.value = '0;
        res.status = ST_OK;
        case (op)
            OP_ADD: begin
                res.value = a + b;
                if (a[W-1] == b[W-1] && res.value[W-1] != a[W-1]) res.status = ST_OVF;
            end
            OP_SUB: begin
                res.value = a - b;
                if (a[W-1] != b[W-1] && res.value[W-1] != a[W-1]) res.status = ST_OVF;
            end
            OP_MUL: begin
                neg = na != nb;
                res.value = a * b;
                p = ma * mb;
                lim = neg ? {1'b0, SMIN} : {1'b0, SMAX};
                if (p > lim) res.status = ST_OVF;
            end
            OP_DIV: begin
                if (mb == 0) begin
                    res.status = ST_DIVZ;
                end else begin
                    neg = na != nb;
                    q = ma / mb;
                    res.value = neg ? -q[W-1:0] : q[W-1:0];
                    if (!neg && q > SMAX) res.status = ST_OVF;
                end
            end
            OP_POW: begin
                if (nb) begin
                    if (ma == 1) res.value = (na && mb[0]) ? '1 : 1;
                    else if (ma == 0) res.status = ST_DIVZ;
                end else begin
                    neg = na && mb[0];
                    lim = neg ? {1'b0, SMIN} : {1'b0, SMAX};
                    // Bases 0 and 1 never grow, so skip the loop for them
                    if (mb == 0) r = 1;
                    else if (ma <= 1) r = ma;
                    else begin
                        r = 1;
                        for (i = 0; i < mb && res.status == ST_OK; i++) begin
                            r = r * ma;
                            if (r > lim) res.status = ST_OVF;
                        end
                    end
                    if (res.status == ST_OVF) res.value = neg ? SMIN : SMAX;
                    else res.value = neg ? -r[W-1:0] : r[W-1:0];
                end
            end
            OP_SGN: res.value = (ma != 0 && mb != 0 && na == nb) ? 1 : 0;
            OP_GCD: begin
                g = euclid(ma, mb);
                if (g > SMAX) begin
                    res.value = SMAX;
                    res.status = ST_OVF;
                end else begin
                    res.value = g[W-1:0];
                end
            end
            default: begin
                if (ma != 0 && mb != 0) begin
                    p = (ma / euclid(ma, mb)) * mb;
                    if (p > SMAX) begin
                        res.value = SMAX;
                        res.status = ST_OVF;
                    end else begin
                        res.value = p[W-1:0];
                    end
                end
            end
        endcase
        return res;
    endfunction

    // Send one item, after a random gap unless gap is cleared, and queue its expected result
    task automatic send_item(t_op op, logic [W-1:0] a, logic [W-1:0] b, bit gap = 1);
        int idle;
        idle = gap ? $urandom_range(0, 11) : 0;
        if (idle != 0) begin
            i_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (!o_ready);
        alu_results_due.push_back(alu_predict(op, a, b));
        items_sent++;
    endtask

    // Drop valid and wait until every expected result has come
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (alu_results_due.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stall per item while enabled, long hold-off on request
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_req) begin
                i_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            stall = rx_idle_en ? $urandom_range(0, 11) : 0;
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_alu_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (alu_results_due.size() == 0) begin
                $display("%0t: result with none expected: value %h status %0d",
                         $time, o_value, o_status);
                error_count++;
            end else begin
                exp_res = alu_results_due.pop_front();
                if (o_value !== exp_res.value) begin
                    $display("%0t: value mismatch: expected %h actual %h",
                             $time, exp_res.value, o_value);
                    error_count++;
                end
                if (o_status !== exp_res.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, exp_res.status, o_status);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [W-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20) - 10;
            1: return SMIN + $urandom_range(0, 2);
            2: return SMAX - $urandom_range(0, 2);
            3: return $urandom_range(0, 70000);
            default: return $urandom();
        endcase
    endfunction

    // Corners of every operation
    task automatic test_directed();
        send_item(OP_ADD, SMAX, 1);
        send_item(OP_ADD, SMIN, SMIN);
        send_item(OP_SUB, SMIN, 1);
        send_item(OP_SUB, '1, SMIN);
        send_item(OP_MUL, 32'h0001_0000, 32'h0000_8000);
        send_item(OP_MUL, 32'hFFFF_0000, 32'h0000_8000);
        send_item(OP_MUL, SMIN, '1);
        send_item(OP_DIV, 7, 0);
        send_item(OP_DIV, SMIN, '1);
        send_item(OP_DIV, -7, 2);
        send_item(OP_POW, 0, 0);
        send_item(OP_POW, -2, 31);
        send_item(OP_POW, 2, 31);
        send_item(OP_POW, 3, SMAX);
        send_item(OP_POW, 1, -5);
        send_item(OP_POW, '1, -3);
        send_item(OP_POW, '1, SMIN);
        send_item(OP_POW, 0, -1);
        send_item(OP_POW, 5, -1);
        send_item(OP_SGN, -3, -4);
        send_item(OP_SGN, 0, 5);
        send_item(OP_GCD, 0, 0);
        send_item(OP_GCD, SMIN, SMIN);
        send_item(OP_GCD, SMIN, 0);
        send_item(OP_LCM, SMAX, SMAX - 1);
        send_item(OP_LCM, 0, -6);
        send_item(OP_LCM, -4, 6);
    endtask

    // Random items over all operations, with small exponents favored for power
    task automatic test_random(int count);
        logic [W-1:0] b;
        t_op op;
        repeat (count) begin
            op = t_op'($urandom_range(0, 7));
            b = rand_operand();
            if (op == OP_POW && $urandom_range(0, 3) != 0) b = $urandom_range(0, 33);
            send_item(op, rand_operand(), b);
        end
    endtask

    // Block the receiver while items keep coming, then drain
    task automatic test_back_pressure();
        hold_off_req = 1'b1;
        repeat (8) send_item(OP_ADD, $urandom(), $urandom(), 0);
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_action = '0;
        i_operand_a = '0;
        i_operand_b = '0;
        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        hold_off_req = 1'b0;
        rx_idle_en = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        test_random(230);
        test_back_pressure();
        rx_idle_en = 1'b0;
        test_random(40);
        rx_idle_en = 1'b1;
        test_random(200);
        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("Sent %0d items over all eight operations, checked %0d results,",
                 items_sent, results_seen);
        $display("including corner operands, stalls and a long output hold-off.");
        if (error_count == 0 && alu_results_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
src/ialu_pkg.sv
src/ialu_div.sv
src/ialu_mul.sv
src/integer_alu_gcd_lcm.sv
verif/tb_integer_alu_gcd_lcm.sv
